@@ rtl/sampled_curve_interpolator_macros.svh @@
// Assertion helpers for the curve interpolator.
// Each helper checks on the rising edge of clk and is off while rst_n is low.
`ifndef SAMPLED_CURVE_INTERPOLATOR_MACROS_SVH
`define SAMPLED_CURVE_INTERPOLATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCI_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sci_pkg.sv @@
package sci_pkg;

    // Fixed point format: ONE stands for 1.0.
    localparam int FRAC_BITS = 16;
    localparam int X_W       = 17;
    localparam int Y_W       = 19;
    localparam int PIDX_W    = 4;
    localparam int COUNT_W   = 5;

    localparam logic [X_W-1:0]        ONE_X = X_W'(1 << FRAC_BITS);
    localparam logic signed [Y_W-1:0] ONE_Y = Y_W'(1 << FRAC_BITS);

    // Request kinds carried on s_tuser.
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_EVAL  = 1'b1;

    // Default table depth.
    localparam int DEF_MAX_POINTS = 16;

    // Datapath widths of the interpolation step.
    localparam int DY_W      = Y_W + 1;        // signed y difference
    localparam int DY_MAG_W  = Y_W;            // its magnitude
    localparam int DX_W      = X_W + 1;        // signed x difference
    localparam int DX_MAG_W  = X_W;            // its magnitude
    localparam int PROD_W    = DY_MAG_W + X_W; // magnitude of dy * dp
    localparam int SUM_W     = PROD_W + 2;     // base plus signed quotient

    // Saturation limits of the result.
    localparam logic signed [SUM_W-1:0] OUT_MIN = -SUM_W'(131072);
    localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'(131072);

    // Stream widths.
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 24;

    // Status of the serial divider as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

@@ rtl/sci_divider.sv @@
module sci_divider #(
    parameter int DIVIDEND_W = sci_pkg::PROD_W,
    parameter int DIVISOR_W  = sci_pkg::DX_MAG_W
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [DIVIDEND_W-1:0]   dividend,
    input  logic [DIVISOR_W-1:0]    divisor,
    output logic [DIVIDEND_W-1:0]   quotient,
    output sci_pkg::div_status_t    status
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg;
    logic                  busy_next;
    logic                  done_reg;
    logic                  done_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  rem_next;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVIDEND_W-1:0] quo_next;
    logic [DIVISOR_W-1:0]  divisor_reg;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    divisor_ext;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    // One restoring step: bring down the next dividend bit and try a subtract.
    assign shifted     = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign divisor_ext = {1'b0, divisor_reg};
    assign fits        = (shifted >= divisor_ext);
    assign diff        = shifted - divisor_ext;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            rem_next  = '0;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Partial remainder and the quotient that shifts in as the dividend shifts out.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            divisor_reg <= divisor;
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

@@ rtl/sampled_curve_interpolator.sv @@
// Write request: accepted while idle; the input stays ready and it gives no result.
// Evaluate request: after acceptance the scan looks for the segment among the points in use;
// then setup, multiply, 36 quotient bits, a check that the divider finished and saturation
// (a segment of no width goes from setup straight to saturation). Input is ready again
// when the result turns valid; an earlier result still held downstream stalls the finish.
// Reset (rst_n low, asynchronous) clears the point count and control, not the sample memory.
`include "sampled_curve_interpolator_macros.svh"

module sampled_curve_interpolator #(
    parameter int MAX_POINTS = sci_pkg::DEF_MAX_POINTS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // s_tdata: point_index[3:0], point_x[20:4], point_y[39:21], progress[56:40], zero fill.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sci_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: kind (0 writes a point, 1 evaluates).
    input  logic                            s_tuser,
    // m_tdata: eased_value[18:0], zero fill.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sci_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sci_pkg::COUNT_W-1:0]     cfg_data
);

    localparam int IDX_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int MEM_DEPTH = 1 << IDX_W;
    localparam int CNT_W     = $clog2(MAX_POINTS + 1);
    localparam int X_W       = sci_pkg::X_W;
    localparam int Y_W       = sci_pkg::Y_W;
    localparam int SUM_W     = sci_pkg::SUM_W;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SCAN   = 6'b000010,
        ST_SETUP  = 6'b000100,
        ST_MUL    = 6'b001000,
        ST_DIV    = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    logic [sci_pkg::COUNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]               cur_idx_reg;
    logic [X_W-1:0]                 p_reg;
    logic [X_W-1:0]                 prev_x_reg;
    logic signed [Y_W-1:0]          prev_y_reg;
    logic [X_W-1:0]                 hi_x_reg;
    logic signed [Y_W-1:0]          hi_y_reg;
    logic [sci_pkg::DY_MAG_W-1:0]   dy_mag_reg;
    logic [sci_pkg::DX_MAG_W-1:0]   dx_mag_reg;
    logic [X_W-1:0]                 dp_reg;
    logic                           neg_reg;
    logic                           zero_dx_reg;
    logic                           m_tvalid_reg;
    logic signed [Y_W-1:0]          eased_reg;

    // Sample memory.
    logic [X_W-1:0]                 x_mem [MEM_DEPTH];
    logic signed [Y_W-1:0]          y_mem [MEM_DEPTH];
    logic [X_W-1:0]                 rd_x_reg;
    logic signed [Y_W-1:0]          rd_y_reg;

    logic                           in_kind;
    logic [sci_pkg::PIDX_W-1:0]     in_index;
    logic [X_W-1:0]                 in_x;
    logic signed [Y_W-1:0]          in_y;
    logic [X_W-1:0]                 in_p;
    logic                           s_fire;
    logic                           wr_en;
    logic [IDX_W+sci_pkg::PIDX_W-1:0] wr_idx_ext;
    logic [IDX_W-1:0]               wr_addr;
    logic [IDX_W-1:0]               rd_addr;
    logic [CNT_W-1:0]               next_idx;
    logic [CNT_W+sci_pkg::COUNT_W-1:0] count_ext;
    logic [CNT_W+sci_pkg::COUNT_W-1:0] max_ext;
    logic [CNT_W-1:0]               scan_limit;
    logic                           scan_end;
    logic                           scan_hit;
    logic signed [sci_pkg::DY_W-1:0] dy_full;
    logic signed [sci_pkg::DX_W-1:0] dx_full;
    logic [sci_pkg::DY_W-1:0]       dy_abs;
    logic [sci_pkg::DX_W-1:0]       dx_abs;
    logic [sci_pkg::PROD_W-1:0]     product;
    logic                           div_start;
    logic [sci_pkg::PROD_W-1:0]     quotient;
    sci_pkg::div_status_t           div_status;
    logic signed [SUM_W-1:0]        q_signed;
    logic signed [SUM_W-1:0]        base_ext;
    logic signed [SUM_W-1:0]        sum;
    logic signed [SUM_W-1:0]        sat;
    logic                           out_free;

    // Request fields.
    assign in_index = s_tdata[3:0];
    assign in_x     = s_tdata[20:4];
    assign in_y     = s_tdata[39:21];
    assign in_p     = s_tdata[56:40];
    assign in_kind  = s_tuser;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Point writes outside the table are dropped.
    assign wr_idx_ext = {IDX_W'(0), in_index};
    assign wr_addr    = wr_idx_ext[IDX_W-1:0];
    assign wr_en      = s_fire && (in_kind == sci_pkg::KIND_WRITE) &&
                        (wr_idx_ext < (IDX_W + sci_pkg::PIDX_W)'(MAX_POINTS));

    // Points in use, limited to the table depth.
    assign count_ext  = {CNT_W'(0), count_reg};
    assign max_ext    = (CNT_W + sci_pkg::COUNT_W)'(MAX_POINTS);
    assign scan_limit = (count_ext > max_ext) ? max_ext[CNT_W-1:0] : count_ext[CNT_W-1:0];

    // The read runs one point ahead of the compare.
    assign next_idx = cur_idx_reg + 1'b1;
    assign rd_addr  = (state_reg == ST_IDLE) ? '0 : next_idx[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            x_mem[wr_addr] <= in_x;
            y_mem[wr_addr] <= in_y;
        end
        rd_x_reg <= x_mem[rd_addr];
        rd_y_reg <= y_mem[rd_addr];
    end

    // Scan decision for the point now read.
    assign scan_end = (cur_idx_reg >= scan_limit);
    assign scan_hit = !scan_end && (rd_x_reg >= p_reg);

    // Differences from the lower point of the segment.
    assign dy_full = {hi_y_reg[Y_W-1], hi_y_reg} - {prev_y_reg[Y_W-1], prev_y_reg};
    assign dx_full = {1'b0, hi_x_reg} - {1'b0, prev_x_reg};
    assign dy_abs  = dy_full[sci_pkg::DY_W-1] ? -dy_full : dy_full;
    assign dx_abs  = dx_full[sci_pkg::DX_W-1] ? -dx_full : dx_full;

    // Product of the magnitudes, registered in the divider.
    assign product   = {(sci_pkg::PROD_W - sci_pkg::DY_MAG_W)'(0), dy_mag_reg} *
                       {(sci_pkg::PROD_W - X_W)'(0), dp_reg};
    assign div_start = (state_reg == ST_MUL);

    sci_divider #(
        .DIVIDEND_W (sci_pkg::PROD_W),
        .DIVISOR_W  (sci_pkg::DX_MAG_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product),
        .divisor  (dx_mag_reg),
        .quotient (quotient),
        .status   (div_status)
    );

    // Add the signed quotient to the segment base and saturate; a segment of no width takes its upper y.
    always_comb
    begin
        q_signed = '0;
        base_ext = SUM_W'(prev_y_reg);
        if (zero_dx_reg)
        begin
            base_ext = SUM_W'(hi_y_reg);
        end
        else
        begin
            q_signed = neg_reg ? -SUM_W'(quotient) : SUM_W'(quotient);
        end
        sum = base_ext + q_signed;
        if (sum < sci_pkg::OUT_MIN)
        begin
            sat = sci_pkg::OUT_MIN;
        end
        else if (sum > sci_pkg::OUT_MAX)
        begin
            sat = sci_pkg::OUT_MAX;
        end
        else
        begin
            sat = sum;
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire && (in_kind == sci_pkg::KIND_EVAL))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_end || scan_hit)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = (dx_full == '0) ? ST_FINISH : ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state, point count and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            cur_idx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
            if (state_reg == ST_IDLE)
            begin
                cur_idx_reg <= '0;
            end
            else if (state_reg == ST_SCAN && !scan_end && !scan_hit)
            begin
                cur_idx_reg <= next_idx;
            end
            if (state_reg == ST_FINISH && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Segment points and operands.
    always_ff @(posedge clk)
    begin
        if (s_fire && (in_kind == sci_pkg::KIND_EVAL))
        begin
            p_reg      <= in_p;
            prev_x_reg <= '0;
            prev_y_reg <= '0;
        end
        if (state_reg == ST_SCAN)
        begin
            if (scan_end)
            begin
                // Past the last point the segment runs to (1, 1). A last point at 1.0
                // leaves no slope, so its own y stands as the result.
                hi_x_reg <= sci_pkg::ONE_X;
                hi_y_reg <= (prev_x_reg == sci_pkg::ONE_X) ? prev_y_reg : sci_pkg::ONE_Y;
            end
            else if (scan_hit)
            begin
                hi_x_reg <= rd_x_reg;
                hi_y_reg <= rd_y_reg;
            end
            else
            begin
                prev_x_reg <= rd_x_reg;
                prev_y_reg <= rd_y_reg;
            end
        end
        if (state_reg == ST_SETUP)
        begin
            dy_mag_reg  <= dy_abs[sci_pkg::DY_MAG_W-1:0];
            dx_mag_reg  <= dx_abs[sci_pkg::DX_MAG_W-1:0];
            dp_reg      <= p_reg - prev_x_reg;
            neg_reg     <= dy_full[sci_pkg::DY_W-1] ^ dx_full[sci_pkg::DX_W-1];
            // A segment with no width returns its upper y.
            zero_dx_reg <= (dx_full == '0);
        end
        if (state_reg == ST_FINISH && out_free)
        begin
            eased_reg <= sat[Y_W-1:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(sci_pkg::M_TDATA_W - Y_W)'(0), eased_reg};

    `SCI_ASSERT_HOLDS(a_div_idle, state_reg != ST_DIV, !div_status.busy, "divider busy outside the divide state")
    `SCI_ASSERT_HOLDS(a_scan_bound, state_reg == ST_SCAN, cur_idx_reg <= scan_limit, "scan index past the points in use")
    `SCI_ASSERT_NEXT(a_result_load, (state_reg == ST_FINISH) && out_free, m_tvalid && (state_reg == ST_IDLE), "result not loaded on finish")

endmodule
